// File: sv/smf_pkg.sv
// ============================================================================
// smf_pkg: shared types and constants for the sliding median filter
// Holds the control state encoding, the sort cell control bundle and the
// fixed field widths and codes used by the filter modules.
// ============================================================================
`default_nettype none

package smf_pkg;

    // Width of the window register and of the held count field.
    localparam int unsigned COUNT_BITS = 5;

    // Window register value after reset.
    localparam logic [COUNT_BITS-1:0] WINDOW_RESET = 5'd16;

    // Input action codes carried on the input tuser.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // Control bundle broadcast to every sort cell.
    typedef struct packed {
        logic clr;  // empty the cell
        logic ins;  // insert the broadcast value in order
        logic shd;  // move every value one cell toward the head
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: sv/smf_sort_cell.sv
// ============================================================================
// smf_sort_cell: one cell of the sorted insertion chain
// Keeps one value and a valid bit. Cells hold values in ascending order from
// the head; an inserted value lands in place while larger values move up.
// ============================================================================
`default_nettype none

module smf_sort_cell #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire smf_pkg::cell_ctl_t      ctl,
    input  wire signed [SAMPLE_BITS-1:0] ins_val,
    input  wire signed [SAMPLE_BITS-1:0] prev_val,
    input  wire                          prev_vld,
    input  wire                          prev_gt,
    input  wire signed [SAMPLE_BITS-1:0] next_val,
    input  wire                          next_vld,
    output logic signed [SAMPLE_BITS-1:0] val,
    output logic                         vld,
    output logic                         gt
);

    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic                          vld_reg, vld_next;

    // The inserted value belongs in front of this cell.
    assign gt  = !vld_reg || (val_reg > ins_val);
    assign val = val_reg;
    assign vld = vld_reg;

    always_comb begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (ctl.clr) begin
            vld_next = 1'b0;
        end else if (ctl.ins) begin
            if (gt) begin
                if (!prev_gt) begin
                    val_next = ins_val;
                    vld_next = 1'b1;
                end else begin
                    val_next = prev_val;
                    vld_next = prev_vld;
                end
            end
        end else if (ctl.shd) begin
            val_next = next_val;
            vld_next = next_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

// File: sv/sliding_median_filter_core.sv
// ============================================================================
// sliding_median_filter_core: median over the most recent samples
// Keeps the last MAX_WINDOW samples in a history chain and, for each new
// sample, sorts the most recent ones through a chain of insertion cells and
// returns their median together with the number of samples it covers.
// ============================================================================
//
//  Channel   Direction  Handshake              Contents
//  --------  ---------  ---------------------  --------------------------------
//  s_        in         s_tvalid / s_tready    tuser: action, tdata: sample
//  m_        out        m_tvalid / m_tready    tdata: median, held_count
//  cfg_      in         cfg_valid / cfg_ready  cfg_data: window_size
//
// A sample's result is loaded after one full turn of the history chain has fed
// the sort chain and head shifts have brought the middle values to the first
// two cells. The input is taken again in the cycle after the load, even while
// a result waits; a stalled output holds the next result in the last step.
// A clear is taken in the idle state and gives no result. Reset empties the
// history and sets the window to 16.
//
`default_nettype none

module sliding_median_filter_core #(
    parameter int unsigned MAX_WINDOW  = 16,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // Input channel.
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire                                  s_tuser,   // [0] action
    input  wire [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // sample
    // Result channel.
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // From bit 0 up: median, held_count, zero padding.
    output logic [((SAMPLE_BITS+smf_pkg::COUNT_BITS+7)/8)*8-1:0] m_tdata,
    // Window size register write channel.
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [smf_pkg::COUNT_BITS-1:0]        cfg_data
);

    localparam int unsigned M_TDATA_W = ((SAMPLE_BITS + smf_pkg::COUNT_BITS + 7) / 8) * 8;
    localparam int unsigned NW   = $clog2(MAX_WINDOW + 1);
    localparam int unsigned CW   = (NW > smf_pkg::COUNT_BITS) ? NW : smf_pkg::COUNT_BITS;
    localparam int unsigned CNTW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    smf_pkg::state_t state_reg, state_next;

    logic [smf_pkg::COUNT_BITS-1:0] win_reg;
    logic [NW-1:0]                  fill_reg, fill_next;
    logic [NW-1:0]                  n_reg, n_next;
    logic [CNTW-1:0]                cnt_reg, cnt_next;
    logic signed [SAMPLE_BITS-1:0]  hist_reg [MAX_WINDOW];
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]           m_tdata_reg, m_tdata_next;

    // ------------------------------------------------------------------
    // Control from the state machine
    // ------------------------------------------------------------------
    smf_pkg::cell_ctl_t ctl;
    logic               hist_shift;
    logic               load_out;
    logic               accept;

    // ------------------------------------------------------------------
    // Window arithmetic
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic [CW-1:0]                 win_ext;
    logic [CW-1:0]                 eff_win;
    logic [CW-1:0]                 fill_inc_ext;
    logic [NW-1:0]                 fill_inc;
    logic [NW-1:0]                 half_val;
    logic [CNTW-1:0]               k_cnt;
    logic                          rot_last;
    logic                          feed_en;

    assign in_sample = s_tdata[SAMPLE_BITS-1:0];
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // A window of zero acts as one; a window above the history depth acts as
    // the full depth.
    assign win_ext = CW'(win_reg);
    always_comb begin
        if (win_ext == '0) begin
            eff_win = CW'(1);
        end else if (win_ext > CW'(MAX_WINDOW)) begin
            eff_win = CW'(MAX_WINDOW);
        end else begin
            eff_win = win_ext;
        end
    end

    // Fill level saturates at the history depth.
    assign fill_inc     = (fill_reg == NW'(MAX_WINDOW)) ? fill_reg : fill_reg + NW'(1);
    assign fill_inc_ext = CW'(fill_inc);

    // Number of head shifts that bring the lower middle value to cell zero.
    assign half_val = (n_reg - NW'(1)) >> 1;
    assign k_cnt    = CNTW'(half_val);

    assign rot_last = (cnt_reg == CNTW'(MAX_WINDOW - 1));

    // During the turn, the history tail holds the sample of age
    // MAX_WINDOW - 1 - cnt; only the n most recent ones enter the sort.
    assign feed_en = (CW'(MAX_WINDOW - 1) - CW'(cnt_reg)) < CW'(n_reg);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smf_pkg::ST_IDLE: begin
                if (s_tvalid && (s_tuser == smf_pkg::ACT_SAMPLE)) begin
                    state_next = smf_pkg::ST_ROTATE;
                end
            end
            smf_pkg::ST_ROTATE: begin
                if (rot_last) begin
                    state_next = (k_cnt == '0) ? smf_pkg::ST_DONE : smf_pkg::ST_SHIFT;
                end
            end
            smf_pkg::ST_SHIFT: begin
                if (cnt_reg == CNTW'(1)) begin
                    state_next = smf_pkg::ST_DONE;
                end
            end
            smf_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = smf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = smf_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_tready   = 1'b0;
        ctl        = '0;
        hist_shift = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            smf_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                ctl.clr    = s_tvalid;
                hist_shift = s_tvalid && (s_tuser == smf_pkg::ACT_SAMPLE);
            end
            smf_pkg::ST_ROTATE: begin
                hist_shift = 1'b1;
                ctl.ins    = feed_en;
            end
            smf_pkg::ST_SHIFT: begin
                ctl.shd = 1'b1;
            end
            smf_pkg::ST_DONE: begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Counters, fill level and window count
    // ------------------------------------------------------------------
    always_comb begin
        fill_next = fill_reg;
        n_next    = n_reg;
        cnt_next  = cnt_reg;
        case (state_reg)
            smf_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    if (s_tuser == smf_pkg::ACT_CLEAR) begin
                        fill_next = '0;
                    end else begin
                        fill_next = fill_inc;
                        n_next    = (fill_inc_ext < eff_win) ? fill_inc : NW'(eff_win);
                    end
                end
            end
            smf_pkg::ST_ROTATE: begin
                cnt_next = rot_last ? k_cnt : cnt_reg + CNTW'(1);
            end
            smf_pkg::ST_SHIFT: begin
                cnt_next = cnt_reg - CNTW'(1);
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= smf_pkg::ST_IDLE;
            win_reg      <= smf_pkg::WINDOW_RESET;
            fill_reg     <= '0;
            n_reg        <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            n_reg        <= n_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                win_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // History chain: a new sample enters at the head; during the turn the
    // tail wraps back to the head so the chain ends where it began.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (hist_shift) begin
            hist_reg[0] <= (state_reg == smf_pkg::ST_IDLE) ? in_sample
                                                         : hist_reg[MAX_WINDOW-1];
            for (int i = 1; i < MAX_WINDOW; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sort chain
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] cell_val [MAX_WINDOW];
    logic                          cell_vld [MAX_WINDOW];
    logic                          cell_gt  [MAX_WINDOW];

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] p_val, n_val;
        logic                          p_vld, p_gt, n_vld;

        if (g == 0) begin : g_head
            assign p_val = '0;
            assign p_vld = 1'b0;
            assign p_gt  = 1'b0;
        end else begin : g_body
            assign p_val = cell_val[g-1];
            assign p_vld = cell_vld[g-1];
            assign p_gt  = cell_gt[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_tail
            assign n_val = '0;
            assign n_vld = 1'b0;
        end else begin : g_inner
            assign n_val = cell_val[g+1];
            assign n_vld = cell_vld[g+1];
        end

        smf_sort_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .ins_val  (hist_reg[MAX_WINDOW-1]),
            .prev_val (p_val),
            .prev_vld (p_vld),
            .prev_gt  (p_gt),
            .next_val (n_val),
            .next_vld (n_vld),
            .val      (cell_val[g]),
            .vld      (cell_vld[g]),
            .gt       (cell_gt[g])
        );
    end

    // ------------------------------------------------------------------
    // Median: an odd count takes the head cell; an even count averages the
    // two head cells with a floor on the half.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] mid_lo, mid_hi, median;
    logic signed [SAMPLE_BITS:0]   mid_sum;

    assign mid_lo = cell_val[0];
    if (MAX_WINDOW > 1) begin : g_mid_two
        assign mid_hi = cell_val[1];
    end else begin : g_mid_one
        assign mid_hi = cell_val[0];
    end

    assign mid_sum = {mid_lo[SAMPLE_BITS-1], mid_lo} + {mid_hi[SAMPLE_BITS-1], mid_hi};
    assign median  = n_reg[0] ? mid_lo : mid_sum[SAMPLE_BITS:1];

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({smf_pkg::COUNT_BITS'(n_reg), median});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: dv/sliding_median_filter_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// sliding_median_filter_core_test: self-checking bench for the median filter
// Drives a table of directed samples and then several phases of random
// samples and clears, each phase under its own window setting. A shadow copy
// of the sample ring computes the expected median and count for every
// accepted sample. Both stream sides idle in random bursts but in the last phase.
// ============================================================================

module sliding_median_filter_core_test;

    localparam int MAX_WINDOW      = 16;
    localparam int SAMPLE_BITS     = 16;
    localparam int RESULT_BITS     = ((SAMPLE_BITS + smf_pkg::COUNT_BITS + 7) / 8) * 8;
    localparam int NUM_DIRECTED    = 25;
    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 64;
    // A sample keeps the block busy through the rotate, shift and done states;
    // leave some margin.
    localparam int DRAIN_CYCLES    = 40;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0]  median;
        logic [smf_pkg::COUNT_BITS-1:0] count;
    } median_result_t;

    typedef struct packed {
        logic                           action;
        logic [SAMPLE_BITS-1:0]         sample;
        logic                           fixed;      // expected result typed in below
        logic [SAMPLE_BITS-1:0]         fix_median;
        logic [smf_pkg::COUNT_BITS-1:0] fix_count;
    } stim_row_t;

    // Extremes, clears, and the even-count rounding toward minus infinity.
    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{smf_pkg::ACT_SAMPLE, 16'h7FFF, 1'b1, 16'h7FFF, 5'd1},
        '{smf_pkg::ACT_SAMPLE, 16'h8000, 1'b1, 16'hFFFF, 5'd2},
        '{smf_pkg::ACT_CLEAR,  16'h1234, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'h8000, 1'b1, 16'h8000, 5'd1},
        '{smf_pkg::ACT_SAMPLE, 16'h8000, 1'b1, 16'h8000, 5'd2},
        '{smf_pkg::ACT_SAMPLE, 16'h8001, 1'b1, 16'h8000, 5'd3},
        '{smf_pkg::ACT_CLEAR,  16'hFFFF, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'h7FFF, 1'b1, 16'h7FFF, 5'd1},
        '{smf_pkg::ACT_SAMPLE, 16'h7FFF, 1'b1, 16'h7FFF, 5'd2},
        '{smf_pkg::ACT_CLEAR,  16'h0000, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'hFFFF, 1'b1, 16'hFFFF, 5'd1},
        '{smf_pkg::ACT_SAMPLE, 16'hFFFE, 1'b1, 16'hFFFE, 5'd2},
        '{smf_pkg::ACT_SAMPLE, 16'h0005, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'h0003, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'hAAAA, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'h5555, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'h0000, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'hFFFF, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'h1000, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'hF000, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'h0001, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'h7FFE, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'h8001, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'h0002, 1'b0, 16'h0000, 5'd0},
        '{smf_pkg::ACT_SAMPLE, 16'hFFFD, 1'b0, 16'h0000, 5'd0}
    };

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic                           s_tuser;    // [0] action
    logic [SAMPLE_BITS-1:0]         s_tdata;    // [15:0] sample
    logic                           m_tvalid;
    logic                           m_tready;
    logic [RESULT_BITS-1:0]         m_tdata;    // [15:0] median, [20:16] held_count, zeros
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [smf_pkg::COUNT_BITS-1:0] cfg_data;

    // Tag that travels with the driven item and tells whether it is typed in.
    logic                           s_fixed;
    logic [SAMPLE_BITS-1:0]         s_fix_median;
    logic [smf_pkg::COUNT_BITS-1:0] s_fix_count;

    // Shadow state of the filter.
    logic signed [SAMPLE_BITS-1:0]  ring [MAX_WINDOW];
    int                             ring_slot;
    int                             ring_fill;
    logic [smf_pkg::COUNT_BITS-1:0] window_reg;

    median_result_t median_queue [$];
    int             fail_count;
    bit             bursts_on;
    int             ready_left;

    sliding_median_filter_core #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void clear_ring();
        for (int i = 0; i < MAX_WINDOW; i++) ring[i] = '0;
        ring_slot = 0;
        ring_fill = 0;
    endfunction

    // Writes one sample into the shadow ring and returns the median of the
    // most recent min(fill, effective window) samples.
    function automatic median_result_t filter_sample(input logic [SAMPLE_BITS-1:0] raw);
        int             sorted [MAX_WINDOW];
        int             eff;
        int             n;
        int             slot;
        int             j;
        int             v;
        int             med;
        median_result_t res;
        ring[ring_slot] = raw;
        ring_slot = (ring_slot + 1) % MAX_WINDOW;
        if (ring_fill < MAX_WINDOW) ring_fill++;
        if (window_reg == 0) eff = 1;
        else if (window_reg > MAX_WINDOW) eff = MAX_WINDOW;
        else eff = window_reg;
        n = (ring_fill < eff) ? ring_fill : eff;
        slot = ring_slot;
        for (int i = 0; i < n; i++) begin
            slot = (slot == 0) ? MAX_WINDOW - 1 : slot - 1;
            v = ring[slot];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        if (n % 2 == 1) med = sorted[n/2];
        else med = (sorted[n/2-1] + sorted[n/2]) >>> 1;
        res.median = med[SAMPLE_BITS-1:0];
        res.count  = n[smf_pkg::COUNT_BITS-1:0];
        return res;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: return SAMPLE_BITS'($urandom_range(0, 8) - 4);
            default: return SAMPLE_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // Result side: random stall bursts while enabled, always ready otherwise.
    always @(posedge aclk) begin
        if (!bursts_on) begin
            m_tready <= 1'b1;
        end else if (ready_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                m_tready   <= 1'b0;
                ready_left <= $urandom_range(0, 17);
            end else begin
                m_tready   <= 1'b1;
                ready_left <= $urandom_range(1, 24);
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    // Observes every transaction: config writes and accepted items update the
    // shadow state, results are checked against the oldest expectation.
    always @(posedge aclk) begin : observe
        median_result_t got;
        median_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.median = m_tdata[SAMPLE_BITS-1:0];
                got.count  = m_tdata[SAMPLE_BITS +: smf_pkg::COUNT_BITS];
                if (median_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: median %0d count %0d",
                                 got.median, got.count);
                end else begin
                    want = median_queue.pop_front();
                    if (got.median !== want.median || got.count !== want.count) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: median exp %0d got %0d, count exp %0d got %0d",
                                     want.median, got.median, want.count, got.count);
                    end
                end
            end
            if (cfg_valid && cfg_ready) window_reg = cfg_data;
            if (s_tvalid && s_tready) begin
                if (s_tuser == smf_pkg::ACT_CLEAR) begin
                    clear_ring();
                end else begin
                    want = filter_sample(s_tdata);
                    if (s_fixed) begin
                        want.median = s_fix_median;
                        want.count  = s_fix_count;
                    end
                    median_queue.push_back(want);
                end
            end
        end
    end

    task automatic send_item(input logic act, input logic [SAMPLE_BITS-1:0] smp,
                             input logic fixed, input logic [SAMPLE_BITS-1:0] fm,
                             input logic [smf_pkg::COUNT_BITS-1:0] fc);
        int gap;
        if (bursts_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid     <= 1'b1;
        s_tuser      <= act;
        s_tdata      <= smp;
        s_fixed      <= fixed;
        s_fix_median <= fm;
        s_fix_count  <= fc;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (median_queue.size() != 0);
    endtask

    // The block must be idle, so any clear still in flight gets time to finish.
    task automatic write_window(input logic [smf_pkg::COUNT_BITS-1:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [smf_pkg::COUNT_BITS-1:0] phase_window [NUM_PHASES];
        stim_row_t                      row;
        logic                           act;
        phase_window = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd2, 5'd17, 5'd0, 5'd7, 5'd3};
        phase_window[6] = smf_pkg::COUNT_BITS'($urandom_range(0, 31));
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tuser      <= smf_pkg::ACT_SAMPLE;
        s_tdata      <= '0;
        s_fixed      <= 1'b0;
        s_fix_median <= '0;
        s_fix_count  <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        m_tready     <= 1'b0;
        ready_left   = 0;
        fail_count   = 0;
        bursts_on    = 1'b1;
        window_reg   = smf_pkg::WINDOW_RESET;
        clear_ring();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            row = DIRECTED_ROWS[r];
            send_item(row.action, row.sample, row.fixed, row.fix_median, row.fix_count);
        end

        // Window changes land without a clear, so each new window applies
        // to history that is already in the ring.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_window(phase_window[p]);
            if (p == NUM_PHASES - 1) bursts_on = 1'b0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p == 2 && k == ITEMS_PER_PHASE / 2) wait_drained();
                act = ($urandom_range(0, 24) == 0) ? smf_pkg::ACT_CLEAR : smf_pkg::ACT_SAMPLE;
                send_item(act, rand_sample(), 1'b0, '0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (median_queue.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/smf_pkg.sv
sv/smf_sort_cell.sv
sv/sliding_median_filter_core.sv
dv/sliding_median_filter_core_test.sv
